>>> src/mbgw_pkg.sv
`timescale 1ns / 1ps

package mbgw_pkg;

  localparam int MAX_HEAP_WORDS = 65536;
  localparam int GREY_DEPTH     = 256;
  localparam int WORD_BITS      = 64;
  localparam int BIT_W          = $clog2(WORD_BITS);
  localparam int BM_WORDS       = (MAX_HEAP_WORDS + WORD_BITS - 1) / WORD_BITS;
  localparam int ROW_W          = $clog2(BM_WORDS);
  localparam int SCAN_W         = ROW_W + 1;
  localparam int POS_W          = ROW_W + BIT_W;
  localparam int GREY_W         = $clog2(GREY_DEPTH);
  localparam int QCNT_W         = GREY_W + 1;
  localparam int OFF_W          = 16;
  localparam int ADDR_W         = 32;
  localparam int HW_W           = 17;
  localparam int REQ_W          = 2;
  localparam int STATUS_W       = 3;
  localparam int CFG_IDX_W      = 1;
  localparam int CFG_DATA_W     = 32;

  typedef enum logic [REQ_W-1:0] {
    REQ_ADD   = 2'd0,
    REQ_TAKE  = 2'd1,
    REQ_SCAN  = 2'd2,
    REQ_CLEAR = 2'd3
  } req_t;

  typedef enum logic [STATUS_W-1:0] {
    ST_OK       = 3'd0,
    ST_BLACK    = 3'd1,
    ST_OUTSIDE  = 3'd2,
    ST_FULL     = 3'd3,
    ST_EMPTY    = 3'd4,
    ST_SCAN_END = 3'd5
  } status_t;

  typedef enum logic [CFG_IDX_W-1:0] {
    CFG_HEAP_BASE  = 1'b0,
    CFG_HEAP_WORDS = 1'b1
  } cfg_reg_t;

  typedef struct packed {
    logic capture;
    logic add_read;
    logic add_finish;
    logic take_read;
    logic take_finish;
    logic scan_read;
    logic scan_check;
    logic ffs_byte;
    logic ffs_bit;
    logic clear_init;
    logic clear_row;
    logic emit;
  } cmd_t;

  typedef struct packed {
    logic outside;
    logic q_empty;
    logic scan_end;
    logic word_hit;
    logic last_word;
    logic clr_last;
    logic out_busy;
  } stat_t;

endpackage

>>> src/mbgw_if.sv
`timescale 1ns / 1ps

interface mbgw_req_if;
  logic                          valid;
  logic                          ready;
  logic [mbgw_pkg::REQ_W-1:0]    req_type;
  logic [mbgw_pkg::ADDR_W-1:0]   node_address;

  modport source (output valid, output req_type, output node_address, input ready);
  modport sink (input valid, input req_type, input node_address, output ready);
endinterface

interface mbgw_res_if;
  logic                          valid;
  logic                          ready;
  logic [mbgw_pkg::STATUS_W-1:0] status;
  logic [mbgw_pkg::OFF_W-1:0]    node_offset;

  modport source (output valid, output status, output node_offset, input ready);
  modport sink (input valid, input status, input node_offset, output ready);
endinterface

>>> src/mbgw_datapath.sv
`timescale 1ns / 1ps

module mbgw_datapath (
  input  logic                              clk,
  input  logic                              rst,
  input  mbgw_pkg::cmd_t                    cmd,
  output mbgw_pkg::stat_t                   stat,
  input  logic [mbgw_pkg::ADDR_W-1:0]       node_address,
  input  logic                              cfg_write,
  input  logic [mbgw_pkg::CFG_IDX_W-1:0]    cfg_index,
  input  logic [mbgw_pkg::CFG_DATA_W-1:0]   cfg_data,
  output logic                              out_valid,
  input  logic                              out_ready,
  output logic [mbgw_pkg::STATUS_W-1:0]     out_status,
  output logic [mbgw_pkg::OFF_W-1:0]        out_offset
);

  logic [mbgw_pkg::WORD_BITS-1:0] bitmap [mbgw_pkg::BM_WORDS];
  logic [mbgw_pkg::OFF_W-1:0]     grey [mbgw_pkg::GREY_DEPTH];

  logic [mbgw_pkg::ADDR_W-1:0]    heap_base;
  logic [mbgw_pkg::HW_W-1:0]      heap_words;
  logic [mbgw_pkg::ADDR_W-1:0]    addr_q;
  logic [mbgw_pkg::POS_W-1:0]     add_pos;
  logic [mbgw_pkg::GREY_W-1:0]    queue_head;
  logic [mbgw_pkg::GREY_W-1:0]    queue_tail;
  logic [mbgw_pkg::QCNT_W-1:0]    queue_count;
  logic [mbgw_pkg::SCAN_W-1:0]    scan_word;
  logic [mbgw_pkg::BIT_W-1:0]     scan_bit;
  logic [mbgw_pkg::ROW_W-1:0]     clr_cnt;
  logic [mbgw_pkg::WORD_BITS-1:0] rd_data;
  logic [mbgw_pkg::OFF_W-1:0]     grey_q;
  logic [mbgw_pkg::WORD_BITS-1:0] hit_word;
  logic [2:0]                     byte_idx;
  logic [7:0]                     hit_byte;
  mbgw_pkg::status_t              res_status;
  logic [mbgw_pkg::OFF_W-1:0]     res_offset;

  logic [mbgw_pkg::ADDR_W:0]      off_full;
  logic [mbgw_pkg::ADDR_W-1:0]    size_eff;
  logic [mbgw_pkg::ROW_W-1:0]     rd_addr;
  logic [mbgw_pkg::ROW_W-1:0]     wr_addr;
  logic [mbgw_pkg::WORD_BITS-1:0] wr_data;
  logic                           wr_en;
  logic                           add_ok;
  logic                           q_full;
  logic [mbgw_pkg::WORD_BITS-1:0] masked;
  logic [2:0]                     byte_sel;
  logic [2:0]                     bit_sel;
  logic [mbgw_pkg::BIT_W-1:0]     hit_pos;

  always_comb begin
    if ({{(mbgw_pkg::ADDR_W-mbgw_pkg::HW_W){1'b0}}, heap_words} >
        mbgw_pkg::ADDR_W'(mbgw_pkg::MAX_HEAP_WORDS)) begin
      size_eff = mbgw_pkg::ADDR_W'(mbgw_pkg::MAX_HEAP_WORDS);
    end else begin
      size_eff = {{(mbgw_pkg::ADDR_W-mbgw_pkg::HW_W){1'b0}}, heap_words};
    end
    off_full = {1'b0, addr_q} - {1'b0, heap_base};
  end

  assign q_full  = (queue_count == mbgw_pkg::QCNT_W'(mbgw_pkg::GREY_DEPTH));
  assign add_ok  = cmd.add_finish && !rd_data[add_pos[mbgw_pkg::BIT_W-1:0]] && !q_full;
  assign masked  = rd_data & ({mbgw_pkg::WORD_BITS{1'b1}} << scan_bit);

  assign stat.outside   = off_full[mbgw_pkg::ADDR_W] ||
                          (off_full[mbgw_pkg::ADDR_W-1:0] >= size_eff);
  assign stat.q_empty   = (queue_count == '0);
  assign stat.scan_end  = (scan_word == mbgw_pkg::SCAN_W'(mbgw_pkg::BM_WORDS));
  assign stat.word_hit  = (masked != '0);
  assign stat.last_word = (scan_word == mbgw_pkg::SCAN_W'(mbgw_pkg::BM_WORDS - 1));
  assign stat.clr_last  = (clr_cnt == mbgw_pkg::ROW_W'(mbgw_pkg::BM_WORDS - 1));
  assign stat.out_busy  = out_valid && !out_ready;

  always_comb begin
    byte_sel = '0;
    for (int i = 7; i >= 0; i--) begin
      if (|hit_word[i*8 +: 8]) begin
        byte_sel = 3'(i);
      end
    end
    bit_sel = '0;
    for (int i = 7; i >= 0; i--) begin
      if (hit_byte[i]) begin
        bit_sel = 3'(i);
      end
    end
    hit_pos = {byte_idx, bit_sel};
  end

  always_comb begin
    if (cmd.add_read) begin
      rd_addr = off_full[mbgw_pkg::POS_W-1:mbgw_pkg::BIT_W];
    end else begin
      rd_addr = scan_word[mbgw_pkg::ROW_W-1:0];
    end
    if (cmd.clear_row) begin
      wr_addr = clr_cnt;
      wr_data = '0;
    end else begin
      wr_addr = add_pos[mbgw_pkg::POS_W-1:mbgw_pkg::BIT_W];
      wr_data = rd_data | (mbgw_pkg::WORD_BITS'(1) << add_pos[mbgw_pkg::BIT_W-1:0]);
    end
    wr_en = cmd.clear_row || add_ok;
  end

  always_ff @(posedge clk) begin
    if (wr_en) begin
      bitmap[wr_addr] <= wr_data;
    end
    rd_data <= bitmap[rd_addr];
  end

  always_ff @(posedge clk) begin
    if (add_ok) begin
      grey[queue_tail] <= mbgw_pkg::OFF_W'(add_pos);
    end
    grey_q <= grey[queue_head];
  end

  always_ff @(posedge clk) begin
    if (cmd.capture) begin
      addr_q <= node_address;
    end
    if (cmd.scan_check) begin
      hit_word <= masked;
    end
    if (cmd.ffs_byte) begin
      byte_idx <= byte_sel;
      hit_byte <= hit_word[byte_sel*8 +: 8];
    end
    if (cmd.add_read) begin
      add_pos    <= off_full[mbgw_pkg::POS_W-1:0];
      res_status <= mbgw_pkg::ST_OUTSIDE;
      res_offset <= stat.outside ? '0 : off_full[mbgw_pkg::OFF_W-1:0];
    end
    if (cmd.add_finish) begin
      if (rd_data[add_pos[mbgw_pkg::BIT_W-1:0]]) begin
        res_status <= mbgw_pkg::ST_BLACK;
      end else if (q_full) begin
        res_status <= mbgw_pkg::ST_FULL;
      end else begin
        res_status <= mbgw_pkg::ST_OK;
      end
    end
    if (cmd.take_read) begin
      res_status <= mbgw_pkg::ST_EMPTY;
      res_offset <= '0;
    end
    if (cmd.take_finish) begin
      res_status <= mbgw_pkg::ST_OK;
      res_offset <= grey_q;
    end
    if ((cmd.scan_read && stat.scan_end) ||
        (cmd.scan_check && !stat.word_hit && stat.last_word)) begin
      res_status <= mbgw_pkg::ST_SCAN_END;
      res_offset <= '0;
    end
    if (cmd.ffs_bit) begin
      res_status <= mbgw_pkg::ST_OK;
      res_offset <= mbgw_pkg::OFF_W'({scan_word[mbgw_pkg::ROW_W-1:0], hit_pos});
    end
    if (cmd.clear_init) begin
      res_status <= mbgw_pkg::ST_OK;
      res_offset <= '0;
    end
    if (cmd.emit) begin
      out_status <= res_status;
      out_offset <= res_offset;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      heap_base   <= '0;
      heap_words  <= mbgw_pkg::HW_W'(mbgw_pkg::MAX_HEAP_WORDS);
      queue_head  <= '0;
      queue_tail  <= '0;
      queue_count <= '0;
      scan_word   <= '0;
      scan_bit    <= '0;
      clr_cnt     <= '0;
      out_valid   <= 1'b0;
    end else begin
      if (cfg_write) begin
        case (cfg_index)
          mbgw_pkg::CFG_HEAP_BASE:  heap_base  <= cfg_data;
          mbgw_pkg::CFG_HEAP_WORDS: heap_words <= cfg_data[mbgw_pkg::HW_W-1:0];
          default: ;
        endcase
      end
      if (add_ok) begin
        queue_tail  <= (queue_tail == mbgw_pkg::GREY_W'(mbgw_pkg::GREY_DEPTH - 1)) ?
                       '0 : queue_tail + 1'b1;
        queue_count <= queue_count + 1'b1;
      end
      if (cmd.take_read && !stat.q_empty) begin
        queue_head  <= (queue_head == mbgw_pkg::GREY_W'(mbgw_pkg::GREY_DEPTH - 1)) ?
                       '0 : queue_head + 1'b1;
        queue_count <= queue_count - 1'b1;
      end
      if (cmd.scan_check && !stat.word_hit) begin
        scan_word <= scan_word + 1'b1;
        scan_bit  <= '0;
      end
      if (cmd.ffs_bit) begin
        if (hit_pos == {mbgw_pkg::BIT_W{1'b1}}) begin
          scan_word <= scan_word + 1'b1;
          scan_bit  <= '0;
        end else begin
          scan_bit  <= hit_pos + 1'b1;
        end
      end
      if (cmd.clear_row) begin
        clr_cnt <= clr_cnt + 1'b1;
      end
      if (cmd.clear_init) begin
        queue_head  <= '0;
        queue_tail  <= '0;
        queue_count <= '0;
        scan_word   <= '0;
        scan_bit    <= '0;
        clr_cnt     <= '0;
      end
      if (cmd.emit) begin
        out_valid <= 1'b1;
      end else if (out_ready) begin
        out_valid <= 1'b0;
      end
    end
  end

endmodule

>>> src/mbgw_ctrl.sv
`timescale 1ns / 1ps

module mbgw_ctrl (
  input  logic                           clk,
  input  logic                           rst,
  input  logic                           in_valid,
  output logic                           in_ready,
  input  logic [mbgw_pkg::REQ_W-1:0]     req_type,
  output mbgw_pkg::cmd_t                 cmd,
  input  mbgw_pkg::stat_t                stat
);

  typedef enum logic [11:0] {
    S_WIPE     = 12'b000000000001,
    S_IDLE     = 12'b000000000010,
    S_ADD_CHK  = 12'b000000000100,
    S_ADD_WR   = 12'b000000001000,
    S_TAKE_RD  = 12'b000000010000,
    S_TAKE_FIN = 12'b000000100000,
    S_SCAN_RD  = 12'b000001000000,
    S_SCAN_CHK = 12'b000010000000,
    S_FFS_BYTE = 12'b000100000000,
    S_FFS_BIT  = 12'b001000000000,
    S_CLEAR    = 12'b010000000000,
    S_DONE     = 12'b100000000000
  } state_t;

  state_t state;
  state_t state_next;

  assign in_ready = (state == S_IDLE);

  always_comb begin
    cmd        = '0;
    state_next = state;
    case (state)
      S_WIPE: begin
        cmd.clear_row = 1'b1;
        if (stat.clr_last) state_next = S_IDLE;
      end
      S_IDLE: begin
        if (in_valid) begin
          cmd.capture = 1'b1;
          case (req_type)
            mbgw_pkg::REQ_ADD:  state_next = S_ADD_CHK;
            mbgw_pkg::REQ_TAKE: state_next = S_TAKE_RD;
            mbgw_pkg::REQ_SCAN: state_next = S_SCAN_RD;
            default: begin
              cmd.clear_init = 1'b1;
              state_next     = S_CLEAR;
            end
          endcase
        end
      end
      S_ADD_CHK: begin
        cmd.add_read = 1'b1;
        state_next   = stat.outside ? S_DONE : S_ADD_WR;
      end
      S_ADD_WR: begin
        cmd.add_finish = 1'b1;
        state_next     = S_DONE;
      end
      S_TAKE_RD: begin
        cmd.take_read = 1'b1;
        state_next    = stat.q_empty ? S_DONE : S_TAKE_FIN;
      end
      S_TAKE_FIN: begin
        cmd.take_finish = 1'b1;
        state_next      = S_DONE;
      end
      S_SCAN_RD: begin
        cmd.scan_read = 1'b1;
        state_next    = stat.scan_end ? S_DONE : S_SCAN_CHK;
      end
      S_SCAN_CHK: begin
        cmd.scan_check = 1'b1;
        if (stat.word_hit) begin
          state_next = S_FFS_BYTE;
        end else if (stat.last_word) begin
          state_next = S_DONE;
        end else begin
          state_next = S_SCAN_RD;
        end
      end
      S_FFS_BYTE: begin
        cmd.ffs_byte = 1'b1;
        state_next   = S_FFS_BIT;
      end
      S_FFS_BIT: begin
        cmd.ffs_bit = 1'b1;
        state_next  = S_DONE;
      end
      S_CLEAR: begin
        cmd.clear_row = 1'b1;
        if (stat.clr_last) state_next = S_DONE;
      end
      S_DONE: begin
        if (!stat.out_busy) begin
          cmd.emit   = 1'b1;
          state_next = S_IDLE;
        end
      end
      default: state_next = S_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= S_WIPE;
    end else begin
      state <= state_next;
    end
  end

endmodule

>>> src/mark_bitmap_with_grey_worklist.sv
`timescale 1ns / 1ps
// Add reads the bitmap word and checks the heap bounds, then, inside the heap, sets the bit
// and pushes the offset onto the grey store; take reads the grey store, then, if not empty,
// returns the offset. Scan reads and checks bitmap words in turn and finds the first set byte
// and bit on a hit; clear sweeps every bitmap word. A new request waits until the result is out,
// a limit set by the bitmap and grey store read-modify-write through one registered read port.
// Reset: synchronous; a sweep zeroes the bitmap before the first word is taken.

module mark_bitmap_with_grey_worklist (
  input  logic                            clk,
  input  logic                            rst,
  mbgw_req_if.sink                        req,
  mbgw_res_if.source                      res,
  input  logic                            cfg_write,
  input  logic [mbgw_pkg::CFG_IDX_W-1:0]  cfg_index,
  input  logic [mbgw_pkg::CFG_DATA_W-1:0] cfg_data
);

  mbgw_pkg::cmd_t  cmd;
  mbgw_pkg::stat_t stat;

  mbgw_ctrl u_ctrl (
    .clk      (clk),
    .rst      (rst),
    .in_valid (req.valid),
    .in_ready (req.ready),
    .req_type (req.req_type),
    .cmd      (cmd),
    .stat     (stat)
  );

  mbgw_datapath u_datapath (
    .clk          (clk),
    .rst          (rst),
    .cmd          (cmd),
    .stat         (stat),
    .node_address (req.node_address),
    .cfg_write    (cfg_write),
    .cfg_index    (cfg_index),
    .cfg_data     (cfg_data),
    .out_valid    (res.valid),
    .out_ready    (res.ready),
    .out_status   (res.status),
    .out_offset   (res.node_offset)
  );

endmodule
